### hdl/sample_voice_mixer_top_assert.svh
// Assertion macros used by the sample voice mixer engine.
`ifndef SAMPLE_VOICE_MIXER_TOP_ASSERT_SVH
`define SAMPLE_VOICE_MIXER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SVM_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("assertion failed: %m");
`define SVM_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("assertion failed: %m");
`else
`define SVM_ASSERT(lbl, prop)
`define SVM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hdl/svm_pkg.sv
// Types, codes and constants of the sample voice mixer.
package svm_pkg;

  localparam int VOICES_DEF       = 24;
  localparam int BED_VOICES_DEF   = 6;
  localparam int SAMPLE_WORDS_DEF = 65536;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_BED   = 2'd2,
    OP_FRAME = 2'd3
  } op_t;

  localparam logic CFG_MASTER_VOLUME = 1'b0;
  localparam logic CFG_GLIDE_RATE    = 1'b1;

  localparam logic [16:0] MV_RESET    = 17'd52429;
  localparam logic [16:0] MV_MAX      = 17'd65536;
  localparam logic [16:0] LEN_MAX     = 17'd65536;
  localparam logic [15:0] GLIDE_RESET = 16'd14;
  localparam logic [15:0] PITCH_MIN   = 16'd2048;
  localparam logic [15:0] PITCH_MAX   = 16'd32768;

  typedef struct packed {
    op_t                op;
    logic [15:0]        sample_addr;
    logic signed [15:0] sample_value;
    logic [16:0]        buffer_length;
    logic [15:0]        gain_left;
    logic [15:0]        gain_right;
    logic [15:0]        pitch;
    logic               loop_flag;
    logic               use_fixed_slot;
    logic [4:0]         slot;
    logic [15:0]        target_gain;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_item_t;

  // Classified request as it waits between front and back
  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [15:0] value;
    logic [16:0] length;
    logic [15:0] gl;
    logic [15:0] gr;
    logic [15:0] step;
    logic        loop;
    logic        fixed;
    logic [4:0]  slot;
    logic [15:0] target;
  } req_t;

endpackage

### hdl/svm_ram.sv
// Generic single-port-write RAM with registered read.
module svm_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### hdl/svm_fifo.sv
// Short queue with full and empty flags.
module svm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW + 1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

### hdl/svm_front.sv
// Front end: accepts requests, clamps and halves fields, queues them for the engine.
module svm_front import svm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  input  logic     req_pop,
  output logic     req_empty,
  output req_t     req
);

  req_t                 cls;
  logic [$bits(req_t)-1:0] req_bits;

  always_comb begin
    cls.op     = in_data.op;
    cls.addr   = in_data.sample_addr;
    cls.value  = in_data.sample_value;
    cls.length = (in_data.buffer_length > LEN_MAX) ? LEN_MAX : in_data.buffer_length;
    cls.gl     = in_data.gain_left;
    cls.gr     = in_data.gain_right;
    priority if (in_data.pitch < PITCH_MIN) begin
      cls.step = PITCH_MIN;
    end else if (in_data.pitch > PITCH_MAX) begin
      cls.step = PITCH_MAX;
    end else begin
      cls.step = in_data.pitch;
    end
    cls.loop   = in_data.loop_flag;
    cls.fixed  = in_data.use_fixed_slot;
    cls.slot   = in_data.slot;
    // bed targets apply half the given gain to both channels
    cls.target = {1'b0, in_data.target_gain[15:1]};
  end

  svm_fifo #(
    .W     ($bits(req_t)),
    .DEPTH (2)
  ) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .din   (cls),
    .pop   (req_pop),
    .empty (req_empty),
    .dout  (req_bits)
  );

  assign req = req_t'(req_bits);

endmodule

### hdl/svm_engine.sv
// Back end: voice state, sample memory and the per-voice mixing sequencer.
`include "sample_voice_mixer_top_assert.svh"
module svm_engine import svm_pkg::*; #(
  parameter int VOICES       = VOICES_DEF,
  parameter int BED_VOICES   = BED_VOICES_DEF,
  parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_empty,
  input  req_t        req,
  output logic        req_pop,
  output logic        out_push,
  input  logic        out_full,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int VW   = $clog2(VOICES);
  localparam int SAW  = $clog2(SAMPLE_WORDS);
  localparam int SW   = (SAW > 17) ? SAW : 17;
  localparam int ACCW = 58;
  localparam logic [VW-1:0] LASTV = VW'(VOICES - 1);
  localparam logic [VW-1:0] FIRST_FREE = VW'(BED_VOICES);

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_START, S_VCHK, S_WRAP, S_RDA, S_RDB, S_CAPB,
    S_MUL1, S_GLD, S_MUL2, S_MUL3, S_ACC, S_OUT
  } state_t;

  state_t state_r;
  req_t   cur_r;

  logic [15:0] base_r  [VOICES];
  logic [16:0] len_r   [VOICES];
  logic [32:0] pos_r   [VOICES];
  logic [15:0] step_r  [VOICES];
  logic [15:0] gl_r    [VOICES];
  logic [15:0] gr_r    [VOICES];
  logic [15:0] tl_r    [VOICES];
  logic [15:0] tr_r    [VOICES];
  logic [VOICES-1:0] loop_r;
  logic [VOICES-1:0] active_r;

  logic [VW-1:0]  v_r, pick_r;
  logic           have_r;
  logic [16:0]    best_r;
  logic [32:0]    wpos_r;
  logic signed [15:0]   a_r, b_r, s_r;
  logic signed [33:0]   dp_r, gdl_r, gdr_r;
  logic signed [32:0]   pl_r, pr_r;
  logic signed [50:0]   ql_r, qr_r;
  logic signed [ACCW-1:0] accl_r, accr_r;
  logic [16:0] mv_r;
  logic [15:0] glide_r;

  // per-voice combinational views at the current voice
  logic [32:0] end_w;
  logic [15:0] i0;
  logic [16:0] i0p1;
  logic [15:0] i1;
  logic [16:0] gsum;
  logic [SW-1:0] rsum, wsum;
  logic [SAW-1:0] raddr, waddr;
  logic [15:0] rdata;
  logic        ram_we;
  logic        last_v;
  logic signed [16:0] diff, frac_s, gdl_in, gdr_in, glide_s;
  logic signed [17:0] s_w;
  logic [15:0] gl_nxt, gr_nxt;

  function automatic logic [15:0] glide_step(input logic [15:0] g,
                                             input logic signed [33:0] d);
    logic signed [33:0] rnd;
    logic signed [18:0] n;
    begin
      rnd = d + 34'sd32768;
      n   = $signed({3'b000, g}) + 19'($signed(rnd[33:16]));
      priority if (n < 19'sd0) begin
        glide_step = 16'd0;
      end else if (n > 19'sd65535) begin
        glide_step = 16'hFFFF;
      end else begin
        glide_step = n[15:0];
      end
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACCW-1:0] acc);
    logic signed [ACCW-33:0] hi;
    begin
      hi = acc[ACCW-1:32];
      priority if (hi > (ACCW - 32)'(32767)) begin
        sat16 = 16'sh7FFF;
      end else if (hi < -(ACCW - 32)'(32768)) begin
        sat16 = -16'sh8000;
      end else begin
        sat16 = hi[15:0];
      end
    end
  endfunction

  assign end_w  = {len_r[v_r], 16'h0000};
  assign i0     = wpos_r[31:16];
  assign i0p1   = {1'b0, i0} + 17'd1;
  assign i1     = (i0p1 < len_r[v_r]) ? i0p1[15:0] : 16'd0;
  assign gsum   = {1'b0, gl_r[v_r]} + {1'b0, gr_r[v_r]};
  assign last_v = (v_r == LASTV);

  always_comb begin
    if (state_r == S_RDB) begin
      rsum = SW'(base_r[v_r]) + SW'(i1);
    end else begin
      rsum = SW'(base_r[v_r]) + SW'(i0);
    end
  end
  assign raddr  = rsum[SAW-1:0];
  assign wsum   = SW'(req.addr);
  assign waddr  = wsum[SAW-1:0];

  assign req_pop  = (state_r == S_IDLE) && !req_empty;
  assign ram_we   = req_pop && (req.op == OP_WRITE);
  assign out_push = (state_r == S_OUT) && !out_full;
  assign out_item.left_out  = sat16(accl_r);
  assign out_item.right_out = sat16(accr_r);

  assign diff    = $signed({b_r[15], b_r}) - $signed({a_r[15], a_r});
  assign frac_s  = $signed({1'b0, wpos_r[15:0]});
  assign gdl_in  = $signed({1'b0, tl_r[v_r]}) - $signed({1'b0, gl_r[v_r]});
  assign gdr_in  = $signed({1'b0, tr_r[v_r]}) - $signed({1'b0, gr_r[v_r]});
  assign glide_s = $signed({1'b0, glide_r});
  assign s_w     = $signed({{2{a_r[15]}}, a_r}) + $signed(dp_r[33:16]);
  assign gl_nxt  = glide_step(gl_r[v_r], gdl_r);
  assign gr_nxt  = glide_step(gr_r[v_r], gdr_r);

  svm_ram #(
    .W     (16),
    .DEPTH (SAMPLE_WORDS)
  ) u_samples (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (req.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= '0;
      mv_r     <= MV_RESET;
      glide_r  <= GLIDE_RESET;
      v_r      <= '0;
      pick_r   <= '0;
      have_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MASTER_VOLUME: mv_r <= (cfg_data > MV_MAX) ? MV_MAX : cfg_data;
          CFG_GLIDE_RATE:    glide_r <= cfg_data[15:0];
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (!req_empty) begin
            cur_r <= req;
            unique case (req.op)
              OP_WRITE: begin
              end
              OP_START: begin
                if (req.fixed) begin
                  if (int'(req.slot) < VOICES) begin
                    pick_r  <= VW'(req.slot);
                    state_r <= S_START;
                  end
                end else if (BED_VOICES < VOICES) begin
                  v_r     <= FIRST_FREE;
                  have_r  <= 1'b0;
                  state_r <= S_ALLOC;
                end
              end
              OP_BED: begin
                if (int'(req.slot) < BED_VOICES && int'(req.slot) < VOICES) begin
                  tl_r[VW'(req.slot)] <= req.target;
                  tr_r[VW'(req.slot)] <= req.target;
                end
              end
              OP_FRAME: begin
                v_r     <= '0;
                accl_r  <= '0;
                accr_r  <= '0;
                state_r <= S_VCHK;
              end
            endcase
          end
        end
        S_ALLOC: begin
          // first idle voice wins, else the quietest seen so far
          if (!active_r[v_r]) begin
            pick_r  <= v_r;
            state_r <= S_START;
          end else begin
            if (!have_r || gsum < best_r) begin
              best_r <= gsum;
              pick_r <= v_r;
              have_r <= 1'b1;
            end
            if (last_v) begin
              state_r <= S_START;
            end else begin
              v_r <= v_r + 1'b1;
            end
          end
        end
        S_START: begin
          base_r[pick_r]   <= cur_r.addr;
          len_r[pick_r]    <= cur_r.length;
          pos_r[pick_r]    <= '0;
          step_r[pick_r]   <= cur_r.step;
          gl_r[pick_r]     <= cur_r.gl;
          tl_r[pick_r]     <= cur_r.gl;
          gr_r[pick_r]     <= cur_r.gr;
          tr_r[pick_r]     <= cur_r.gr;
          loop_r[pick_r]   <= cur_r.loop;
          active_r[pick_r] <= 1'b1;
          state_r          <= S_IDLE;
        end
        S_VCHK: begin
          wpos_r <= pos_r[v_r];
          if (!active_r[v_r] || len_r[v_r] == '0) begin
            state_r <= last_v ? S_OUT : S_VCHK;
            v_r     <= last_v ? v_r : v_r + 1'b1;
          end else if (pos_r[v_r] >= end_w) begin
            if (loop_r[v_r]) begin
              state_r <= S_WRAP;
            end else begin
              active_r[v_r] <= 1'b0;
              state_r <= last_v ? S_OUT : S_VCHK;
              v_r     <= last_v ? v_r : v_r + 1'b1;
            end
          end else begin
            state_r <= S_RDA;
          end
        end
        S_WRAP: begin
          // reduce modulo the buffer end one subtraction a cycle
          if (wpos_r >= end_w) begin
            wpos_r <= wpos_r - end_w;
          end else begin
            state_r <= S_RDA;
          end
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          a_r     <= rdata;
          state_r <= S_CAPB;
        end
        S_CAPB: begin
          b_r     <= rdata;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          dp_r    <= diff * frac_s;
          gdl_r   <= gdl_in * glide_s;
          gdr_r   <= gdr_in * glide_s;
          state_r <= S_GLD;
        end
        S_GLD: begin
          s_r       <= s_w[15:0];
          gl_r[v_r] <= gl_nxt;
          gr_r[v_r] <= gr_nxt;
          state_r   <= S_MUL2;
        end
        S_MUL2: begin
          pl_r    <= s_r * $signed({1'b0, gl_r[v_r]});
          pr_r    <= s_r * $signed({1'b0, gr_r[v_r]});
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          ql_r    <= pl_r * $signed({1'b0, mv_r});
          qr_r    <= pr_r * $signed({1'b0, mv_r});
          state_r <= S_ACC;
        end
        S_ACC: begin
          accl_r     <= accl_r + ACCW'(ql_r);
          accr_r     <= accr_r + ACCW'(qr_r);
          pos_r[v_r] <= wpos_r + {14'd0, step_r[v_r], 3'b000};
          state_r    <= last_v ? S_OUT : S_VCHK;
          v_r        <= last_v ? v_r : v_r + 1'b1;
        end
        S_OUT: begin
          if (!out_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SVM_ASSERT(a_wrap_in_range, (state_r == S_RDA) |-> (wpos_r < end_w))
  `SVM_ASSERT(a_frame_delivered, ((state_r == S_IDLE) && ($past(state_r) == S_OUT)) |-> $past(out_push))
  `SVM_ASSERT_ALWAYS(a_reset_idles_voices, (!rst_n) |=> (active_r == '0))

endmodule

### hdl/sample_voice_mixer_top.sv
// Top level of the multi-voice sample player and stereo mixer.
// Input queue: drive in_data and raise in_push; the request is taken on a
// clock edge where in_full is low. Ops: write a sample word, start a voice
// (fixed slot or allocated), set a bed voice target, or request a frame.
// Result queue: a frame is shown on out_data while out_empty is low and is
// taken on an edge with out_pop high. Only frame requests make a result.
// Requests wait in a two-entry queue; results in a two-entry queue, so a
// stalled receiver stops the engine only once both slots are full.
// Timing is set by the per-voice sequencer and the single sample RAM: a
// write or bed request is handled in the idle state, a fixed start passes
// through the start state, and an allocated start first scans the non-bed
// voices. A frame visits each voice in turn; an active voice reads two
// samples, interpolates, glides its gains, scales and accumulates, and a
// looping voice past its end is first wrapped by repeated subtraction.
// Reset (rst_n low, synchronous) idles all voices, empties both queues and
// loads master volume 0.8 and glide rate 14. Sample memory is not cleared.
// Configuration writes (cfg_we) take effect at once.
module sample_voice_mixer_top import svm_pkg::*; #(
  parameter int VOICES       = VOICES_DEF,
  parameter int BED_VOICES   = BED_VOICES_DEF,
  parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  req_t      req;
  logic      req_empty, req_pop;
  logic      res_push, res_full;
  out_item_t res_item;
  logic [$bits(out_item_t)-1:0] out_bits;

  svm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .req_pop   (req_pop),
    .req_empty (req_empty),
    .req       (req)
  );

  svm_engine #(
    .VOICES       (VOICES),
    .BED_VOICES   (BED_VOICES),
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_empty (req_empty),
    .req       (req),
    .req_pop   (req_pop),
    .out_push  (res_push),
    .out_full  (res_full),
    .out_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  svm_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res_item),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (out_bits)
  );

  assign out_data = out_item_t'(out_bits);

endmodule
